### design/ccrg_pkg.sv
`timescale 1ns / 1ps

package ccrg_pkg;

  localparam int CELL_COUNT_DEF = 18;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] CKS_INIT = 16'ha5a5;
  localparam logic [15:0] V_NONE   = 16'hfffe;
  localparam logic [15:0] V_OPEN   = 16'hfffd;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_ID      = 2'd0,
    CFG_HEARTBEAT_CMD = 2'd1,
    CFG_EMC_CMD       = 2'd2,
    CFG_PC_CMD        = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FS_STORED   = 3'd0,
    FS_LEN_OVER = 3'd1,
    FS_OTHER_ID = 3'd2,
    FS_CHK_BAD  = 3'd3,
    FS_NOT_CELL = 3'd4,
    FS_LEN_NOT8 = 3'd5
  } frame_status_e;

  typedef enum logic [1:0] {
    CS_READING   = 2'd0,
    CS_NOT_INST  = 2'd1,
    CS_OPEN_WIRE = 2'd2,
    CS_NOT_RCVD  = 2'd3
  } cell_status_e;

  typedef struct packed {
    logic          load;
    logic          cnt_clr;
    logic          cnt_inc;
    logic          chk_add;
    logic          grp_load;
    logic          cell_emit;
    logic          store_wr;
    logic          stat_emit;
    frame_status_e stat_code;
  } ccrg_cmd_t;

  typedef struct packed {
    logic len_over;
    logic sum_more;
    logic id_ok;
    logic chk_ok;
    logic cmd_ok;
    logic grp_change;
    logic len_eight;
    logic cnt_last;
    logic store_last;
    logic out_free;
  } ccrg_sts_t;

endpackage

### design/ccrg_if.sv
`timescale 1ns / 1ps

interface ccrg_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  seq_byte;
  logic [31:0] frame_id;
  logic [7:0]  length;
  logic [63:0] payload;
  logic [7:0]  line_check;

  modport source (output valid, seq_byte, frame_id, length, payload, line_check,
                  input ready);
  modport sink (input valid, seq_byte, frame_id, length, payload, line_check,
                output ready);
endinterface

interface ccrg_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  frame_status;
  logic [4:0]  cell_index;
  logic [15:0] cell_value;
  logic [1:0]  cell_status;
  logic        last;

  modport source (output valid, kind, frame_status, cell_index, cell_value, cell_status,
                  last, input ready);
  modport sink (input valid, kind, frame_status, cell_index, cell_value, cell_status,
                last, output ready);
endinterface

### design/can_cell_reading_gatherer_unit.sv
`timescale 1ns / 1ps
// CAN cell reading gatherer.
// in_i carries one decoded CAN frame per word; out_o returns result words.
// Each frame gives zero or CELL_COUNT cell results (kind 1, on a group
// change), then one frame status result with last set.
// cfg_we_i/cfg_idx_i/cfg_data_i write match_id, heartbeat_cmd, emc_cmd and
// pc_cmd; write them only while the block is idle.
// Flow: one frame is worked on at a time. After acceptance the checksum
// adds the payload bytes in turn (no bytes when length is over 8), then
// a check step decides the outcome. A group change streams CELL_COUNT cell
// results at one per cycle while out_o is not stalled, a length-8 frame
// writes three readings, and then the status result is issued.
// The next frame can be taken in the cycle after the status word is issued;
// it may still wait in the output register then.
// Reset clears the configuration, the group number and all received flags;
// the cell store needs no clearing pass. A stalled receiver holds the
// output word and pauses the flush.

module can_cell_reading_gatherer_unit
  import ccrg_pkg::*;
#(
  parameter int CELL_COUNT = CELL_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ccrg_in_if.sink               in_i,
  ccrg_out_if.source            out_o
);

  ccrg_cmd_t cmd;
  ccrg_sts_t sts;

  ccrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ccrg_dp #(
    .CELL_COUNT (CELL_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .seq_byte_i     (in_i.seq_byte),
    .frame_id_i     (in_i.frame_id),
    .length_i       (in_i.length),
    .payload_i      (in_i.payload),
    .line_check_i   (in_i.line_check),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .kind_o         (out_o.kind),
    .frame_status_o (out_o.frame_status),
    .cell_index_o   (out_o.cell_index),
    .cell_value_o   (out_o.cell_value),
    .cell_status_o  (out_o.cell_status),
    .last_o         (out_o.last)
  );

endmodule

### design/ccrg_ctrl.sv
`timescale 1ns / 1ps

module ccrg_ctrl
  import ccrg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ccrg_sts_t sts_i,
  output ccrg_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SUM    = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_FLUSH  = 3'd3;
  localparam logic [2:0] S_STORE  = 3'd4;
  localparam logic [2:0] S_REPORT = 3'd5;

  logic [2:0]    state_q, state_d;
  frame_status_e code_q, code_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d         = state_q;
    code_d          = code_q;
    cmd_o           = '0;
    cmd_o.stat_code = code_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_SUM;
        end
      end
      S_SUM: begin
        if (sts_i.sum_more) begin
          cmd_o.chk_add = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.len_over) begin
          code_d  = FS_LEN_OVER;
          state_d = S_REPORT;
        end else if (!sts_i.id_ok) begin
          code_d  = FS_OTHER_ID;
          state_d = S_REPORT;
        end else if (!sts_i.chk_ok) begin
          code_d  = FS_CHK_BAD;
          state_d = S_REPORT;
        end else if (!sts_i.cmd_ok) begin
          code_d  = FS_NOT_CELL;
          state_d = S_REPORT;
        end else if (sts_i.grp_change) begin
          cmd_o.grp_load = 1'b1;
          cmd_o.cnt_clr  = 1'b1;
          state_d        = S_FLUSH;
        end else if (sts_i.len_eight) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_STORE;
        end else begin
          code_d  = FS_LEN_NOT8;
          state_d = S_REPORT;
        end
      end
      S_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.cell_emit = 1'b1;
          if (sts_i.cnt_last) begin
            if (sts_i.len_eight) begin
              cmd_o.cnt_clr = 1'b1;
              state_d       = S_STORE;
            end else begin
              code_d  = FS_LEN_NOT8;
              state_d = S_REPORT;
            end
          end else begin
            cmd_o.cnt_inc = 1'b1;
          end
        end
      end
      S_STORE: begin
        cmd_o.store_wr = 1'b1;
        if (sts_i.store_last) begin
          code_d  = FS_STORED;
          state_d = S_REPORT;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_REPORT: begin
        if (sts_i.out_free) begin
          cmd_o.stat_emit = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= FS_STORED;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

endmodule

### design/ccrg_dp.sv
`timescale 1ns / 1ps

module ccrg_dp
  import ccrg_pkg::*;
#(
  parameter int CELL_COUNT = CELL_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]            seq_byte_i,
  input  logic [31:0]           frame_id_i,
  input  logic [7:0]            length_i,
  input  logic [63:0]           payload_i,
  input  logic [7:0]            line_check_i,
  input  ccrg_cmd_t             cmd_i,
  output ccrg_sts_t             sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  kind_o,
  output logic [2:0]            frame_status_o,
  output logic [4:0]            cell_index_o,
  output logic [15:0]           cell_value_o,
  output logic [1:0]            cell_status_o,
  output logic                  last_o
);

  localparam int IW = $clog2(CELL_COUNT);

  logic [31:0] match_id_q;
  logic [7:0]  hb_cmd_q, emc_cmd_q, pc_cmd_q;

  logic [31:0] id_q;
  logic [7:0]  len_q;
  logic [63:0] pay_q;
  logic [7:0]  lchk_q;
  logic [15:0] chk_q, chk_d;
  logic [3:0]  grp_q;
  logic [IW-1:0] cnt_q, cnt_d;

  logic [15:0] cell_mem [CELL_COUNT];
  logic [15:0] rdata_q;
  logic [CELL_COUNT-1:0] rcv_q;

  logic          out_vld_q;
  logic          kind_q, last_q;
  frame_status_e fs_q;
  logic [4:0]    idx_q;
  logic [15:0]   val_q;
  cell_status_e  cst_q;

  logic [7:0]    sum_byte;
  logic [16:0]   fold1, fold2;
  logic [7:0]    b0, b1;
  logic [IW-1:0] pos;
  logic          pos_ok;
  logic [15:0]   st_word;
  logic          rcv_cur;
  cell_status_e  cell_st;
  logic [15:0]   cell_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_id_q <= '0;
      hb_cmd_q   <= '0;
      emc_cmd_q  <= '0;
      pc_cmd_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MATCH_ID:      match_id_q <= cfg_data_i[31:0];
        CFG_HEARTBEAT_CMD: hb_cmd_q   <= cfg_data_i[7:0];
        CFG_EMC_CMD:       emc_cmd_q  <= cfg_data_i[7:0];
        CFG_PC_CMD:        pc_cmd_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign b0       = pay_q[7:0];
  assign b1       = pay_q[15:8];
  assign sum_byte = pay_q[{cnt_q[2:0], 3'b000} +: 8];

  always_comb begin
    chk_d = chk_q;
    if (cmd_i.load) begin
      chk_d = CKS_INIT + 16'(seq_byte_i) + 16'(length_i)
            + 16'(frame_id_i[7:0]) + 16'(frame_id_i[15:8])
            + 16'(frame_id_i[23:16]) + 16'(frame_id_i[31:24]);
    end else if (cmd_i.chk_add) begin
      chk_d = chk_q + 16'(sum_byte);
    end
  end

  // fold; the running sum stays below 2^16, so the 16-bit folds add nothing
  assign fold1 = {1'b0, chk_q} + 17'(chk_q[15:8]);
  assign fold2 = fold1 + 17'(fold1[16:8]);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q   <= frame_id_i;
      len_q  <= length_i;
      pay_q  <= payload_i;
      lchk_q <= line_check_i;
    end
    chk_q <= chk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      grp_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.grp_load) begin
        grp_q <= b1[3:0];
      end
    end
  end

  assign pos    = IW'(b1[7:4]) + IW'(cnt_q[1:0]);
  assign pos_ok = {1'b0, pos} < (IW+1)'(CELL_COUNT);

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    st_word = pay_q[31:16];
      2'd1:    st_word = pay_q[47:32];
      default: st_word = pay_q[63:48];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr && pos_ok) begin
      cell_mem[pos] <= st_word;
    end
    rdata_q <= cell_mem[cnt_d];
  end

  assign rcv_cur = rcv_q[cnt_q];

  always_comb begin
    cell_val = rdata_q;
    if (!rcv_cur) begin
      cell_st  = CS_NOT_RCVD;
      cell_val = '0;
    end else if (rdata_q == V_NONE) begin
      cell_st = CS_NOT_INST;
    end else if (rdata_q == V_OPEN) begin
      cell_st = CS_OPEN_WIRE;
    end else begin
      cell_st = CS_READING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_q <= '0;
    end else if (cmd_i.cell_emit && rcv_cur && cell_st == CS_READING) begin
      rcv_q[cnt_q] <= 1'b0;
    end else if (cmd_i.store_wr && pos_ok) begin
      rcv_q[pos] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.cell_emit || cmd_i.stat_emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_emit) begin
      kind_q <= 1'b1;
      fs_q   <= FS_STORED;
      idx_q  <= 5'(cnt_q);
      val_q  <= cell_val;
      cst_q  <= cell_st;
      last_q <= 1'b0;
    end else if (cmd_i.stat_emit) begin
      kind_q <= 1'b0;
      fs_q   <= cmd_i.stat_code;
      idx_q  <= '0;
      val_q  <= '0;
      cst_q  <= CS_READING;
      last_q <= 1'b1;
    end
  end

  assign sts_o.len_over   = len_q > 8'd8;
  assign sts_o.sum_more   = !sts_o.len_over && (8'(cnt_q) < len_q);
  assign sts_o.id_ok      = id_q == match_id_q;
  assign sts_o.chk_ok     = fold2[7:0] == lchk_q;
  assign sts_o.cmd_ok     = (b0 == hb_cmd_q) || (b0 == emc_cmd_q) || (b0 == pc_cmd_q);
  assign sts_o.grp_change = b1[3:0] != grp_q;
  assign sts_o.len_eight  = len_q == 8'd8;
  assign sts_o.cnt_last   = cnt_q == IW'(CELL_COUNT - 1);
  assign sts_o.store_last = cnt_q == IW'(2);
  assign sts_o.out_free   = !out_vld_q || out_ready_i;

  assign out_valid_o    = out_vld_q;
  assign kind_o         = kind_q;
  assign frame_status_o = fs_q;
  assign cell_index_o   = idx_q;
  assign cell_value_o   = val_q;
  assign cell_status_o  = cst_q;
  assign last_o         = last_q;

endmodule

### design/ccrg_checker.sv
`timescale 1ns / 1ps

module ccrg_checker
  import ccrg_pkg::*;
#(
  parameter int CELL_COUNT = CELL_COUNT_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        kind_i,
  input logic [2:0]  frame_status_i,
  input logic [4:0]  cell_index_i,
  input logic [15:0] cell_value_i,
  input logic [1:0]  cell_status_i,
  input logic        last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i
      && $stable({kind_i, frame_status_i, cell_index_i, cell_value_i, cell_status_i, last_i}))
    else $error("output word changed while stalled");

  a_cell_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i |-> !last_i && frame_status_i == FS_STORED
      && cell_index_i < CELL_COUNT)
    else $error("malformed cell result");

  a_status_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !kind_i |-> last_i && cell_index_i == '0 && cell_value_i == '0
      && cell_status_i == CS_READING)
    else $error("malformed status result");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("frame accepted while busy");

endmodule

bind can_cell_reading_gatherer_unit ccrg_checker #(
  .CELL_COUNT (CELL_COUNT)
) u_ccrg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .frame_status_i (out_o.frame_status),
  .cell_index_i   (out_o.cell_index),
  .cell_value_i   (out_o.cell_value),
  .cell_status_i  (out_o.cell_status),
  .last_i         (out_o.last)
);

### tb/can_cell_reading_gatherer_unit_tb.sv
`timescale 1ns / 1ps

module can_cell_reading_gatherer_unit_tb;
  import ccrg_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 40;

  typedef struct packed {
    logic [7:0]  seq;
    logic [31:0] id;
    logic [7:0]  len;
    logic [63:0] pay;
    logic [7:0]  chk;
  } frame_t;

  typedef struct packed {
    logic          kind;
    frame_status_e fs;
    logic [4:0]    idx;
    logic [15:0]   val;
    cell_status_e  cs;
    logic          last;
  } result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ccrg_in_if  in_if ();
  ccrg_out_if out_if ();

  can_cell_reading_gatherer_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // expected behavior state
  logic [31:0] cfg_match;
  logic [7:0]  cfg_hb;
  logic [7:0]  cfg_emc;
  logic [7:0]  cfg_pc;
  logic [15:0] cell_val [CELL_COUNT_DEF];
  logic        cell_seen [CELL_COUNT_DEF];
  logic [3:0]  grp_nib;

  frame_t  frames_q [$];
  result_t due_words [$];

  frame_t  next_frame;
  result_t got;
  result_t want;
  logic    in_took;
  logic    calm;
  logic    long_done;
  int      gap_cnt;
  int      hold_cnt;
  int      frames_taken;
  int      stall_cycles;
  int      errors;
  logic [3:0] grp_next;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [7:0] frame_sum(frame_t f);
    logic [31:0] s;
    s = 32'(CKS_INIT) + f.seq + f.len;
    for (int i = 0; i < 4; i++) s += f.id[8*i +: 8];
    for (int i = 0; i < 8; i++) if (i < f.len) s += f.pay[8*i +: 8];
    s += s >> 16;
    s += s >> 16;
    s += s >> 8;
    s += s >> 8;
    return s[7:0];
  endfunction

  function automatic result_t status_word(frame_status_e s);
    return '{1'b0, s, 5'd0, 16'd0, CS_READING, 1'b1};
  endfunction

  function automatic void gather_frame(frame_t f);
    logic [7:0]   b0;
    logic [7:0]   b1;
    logic [15:0]  v;
    cell_status_e st;
    int           pos;
    b0 = f.pay[7:0];
    b1 = f.pay[15:8];
    if (f.len > 8) begin
      due_words.push_back(status_word(FS_LEN_OVER));
      return;
    end
    if (f.id != cfg_match) begin
      due_words.push_back(status_word(FS_OTHER_ID));
      return;
    end
    if (frame_sum(f) != f.chk) begin
      due_words.push_back(status_word(FS_CHK_BAD));
      return;
    end
    if (b0 != cfg_hb && b0 != cfg_emc && b0 != cfg_pc) begin
      due_words.push_back(status_word(FS_NOT_CELL));
      return;
    end
    if (b1[3:0] != grp_nib) begin
      for (int i = 0; i < CELL_COUNT_DEF; i++) begin
        v = cell_val[i];
        if (!cell_seen[i]) begin
          st = CS_NOT_RCVD;
          v = '0;
        end else if (v == V_NONE) begin
          st = CS_NOT_INST;
        end else if (v == V_OPEN) begin
          st = CS_OPEN_WIRE;
        end else begin
          st = CS_READING;
          cell_seen[i] = 1'b0;
        end
        due_words.push_back('{1'b1, FS_STORED, 5'(i), v, st, 1'b0});
      end
      grp_nib = b1[3:0];
    end
    if (f.len != 8) begin
      due_words.push_back(status_word(FS_LEN_NOT8));
      return;
    end
    for (int i = 0; i < 3; i++) begin
      pos = b1[7:4] + i;
      if (pos < CELL_COUNT_DEF) begin
        cell_val[pos] = f.pay[16*(i+1) +: 16];
        cell_seen[pos] = 1'b1;
      end
    end
    due_words.push_back(status_word(FS_STORED));
  endfunction

  function automatic frame_t cell_frame(input logic [7:0] cmd, input logic [3:0] grp,
                                        input logic [3:0] base, input logic [15:0] v0,
                                        input logic [15:0] v1, input logic [15:0] v2,
                                        input logic [7:0] len);
    frame_t f;
    f.seq = 8'($urandom);
    f.id  = cfg_match;
    f.len = len;
    f.pay = {v2, v1, v0, base, grp, cmd};
    f.chk = frame_sum(f);
    return f;
  endfunction

  task automatic note_mismatch(string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic set_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_all(logic [31:0] id, logic [7:0] hb, logic [7:0] emc, logic [7:0] pc);
    set_reg(CFG_MATCH_ID, id);
    set_reg(CFG_HEARTBEAT_CMD, 32'(hb));
    set_reg(CFG_EMC_CMD, 32'(emc));
    set_reg(CFG_PC_CMD, 32'(pc));
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (frames_q.size() != 0 || in_if.valid || due_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_random(int n);
    frame_t      f;
    int          pick;
    logic [7:0]  cmd;
    logic [15:0] v [3];
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) grp_next = 4'($urandom);
      case ($urandom_range(0, 2))
        0: cmd = cfg_hb;
        1: cmd = cfg_emc;
        default: cmd = cfg_pc;
      endcase
      for (int j = 0; j < 3; j++) begin
        case ($urandom_range(0, 4))
          0: v[j] = V_NONE;
          1: v[j] = V_OPEN;
          default: v[j] = 16'($urandom);
        endcase
      end
      f = cell_frame(cmd, grp_next, 4'($urandom), v[0], v[1], v[2],
                     ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 7)) : 8'd8);
      if (pick >= 92) begin
        do f.pay[7:0] = 8'($urandom);
        while (f.pay[7:0] == cfg_hb || f.pay[7:0] == cfg_emc || f.pay[7:0] == cfg_pc);
        f.chk = frame_sum(f);
      end else if (pick >= 85) begin
        f.len = 8'($urandom_range(9, 255));
        f.pay = {$urandom, $urandom};
        f.chk = 8'($urandom);
      end else if (pick >= 78) begin
        f.chk = f.chk ^ 8'($urandom_range(1, 255));
      end else if (pick >= 70) begin
        f.id = $urandom;
        if (f.id == cfg_match) f.id = ~f.id;
        if ($urandom_range(0, 1) == 0) f.chk = frame_sum(f);
      end
      frames_q.push_back(f);
    end
  endtask

  // drive input words
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_took) begin
      // hold
    end else if (gap_cnt != 0) begin
      gap_cnt <= gap_cnt - 1;
      in_if.valid <= 1'b0;
    end else if (frames_q.size() == 0) begin
      in_if.valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      gap_cnt <= $urandom_range(0, 6);
      in_if.valid <= 1'b0;
    end else begin
      next_frame = frames_q.pop_front();
      in_if.valid      <= 1'b1;
      in_if.seq_byte   <= next_frame.seq;
      in_if.frame_id   <= next_frame.id;
      in_if.length     <= next_frame.len;
      in_if.payload    <= next_frame.pay;
      in_if.line_check <= next_frame.chk;
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (!long_done && frames_taken >= HOLD_AT) begin
      long_done <= 1'b1;
      hold_cnt <= LONG_HOLD;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      hold_cnt <= $urandom_range(0, 6);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    in_took <= in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (cfg_we) begin
        case (cfg_idx_e'(cfg_idx))
          CFG_MATCH_ID:      cfg_match = cfg_data;
          CFG_HEARTBEAT_CMD: cfg_hb    = cfg_data[7:0];
          CFG_EMC_CMD:       cfg_emc   = cfg_data[7:0];
          CFG_PC_CMD:        cfg_pc    = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        got = {out_if.kind, out_if.frame_status, out_if.cell_index, out_if.cell_value,
               out_if.cell_status, out_if.last};
        if (due_words.size() == 0) begin
          note_mismatch($sformatf("unexpected word kind=%0d fs=%0d idx=%0d val=%0h",
                                  got.kind, got.fs, got.idx, got.val));
        end else begin
          want = due_words.pop_front();
          if (got.kind !== want.kind)
            note_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
          if (got.fs !== want.fs)
            note_mismatch($sformatf("frame_status got %0d want %0d", got.fs, want.fs));
          if (got.idx !== want.idx)
            note_mismatch($sformatf("cell_index got %0d want %0d", got.idx, want.idx));
          if (got.val !== want.val)
            note_mismatch($sformatf("cell_value got %0h want %0h (cell %0d)",
                                    got.val, want.val, want.idx));
          if (got.cs !== want.cs)
            note_mismatch($sformatf("cell_status got %0d want %0d (cell %0d)",
                                    got.cs, want.cs, want.idx));
          if (got.last !== want.last)
            note_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
        end
      end
      if (in_if.valid && in_if.ready) begin
        gather_frame('{in_if.seq_byte, in_if.frame_id, in_if.length, in_if.payload,
                       in_if.line_check});
        frames_taken++;
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("can_cell_reading_gatherer_unit_tb failed");
          $finish;
        end
      end
    end
  end

  initial begin
    frame_t f;
    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    in_if.valid      = 1'b0;
    in_if.seq_byte   = '0;
    in_if.frame_id   = '0;
    in_if.length     = '0;
    in_if.payload    = '0;
    in_if.line_check = '0;
    out_if.ready     = 1'b0;
    cfg_match = '0;
    cfg_hb    = '0;
    cfg_emc   = '0;
    cfg_pc    = '0;
    grp_nib   = '0;
    for (int i = 0; i < CELL_COUNT_DEF; i++) begin
      cell_val[i]  = '0;
      cell_seen[i] = 1'b0;
    end
    in_took      = 1'b0;
    calm         = 1'b0;
    long_done    = 1'b0;
    gap_cnt      = 0;
    hold_cnt     = 0;
    frames_taken = 0;
    stall_cycles = 0;
    errors       = 0;
    grp_next     = '0;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_all(32'hffff_ffff, 8'h00, 8'hff, 8'h5a);
    frames_q.push_back('{8'hff, 32'hffff_ffff, 8'hff, 64'hffff_ffff_ffff_ffff, 8'hff});
    frames_q.push_back('{8'h00, 32'h0000_0000, 8'd9, 64'h0, 8'h00});
    f = cell_frame(8'h00, 4'd1, 4'd0, 16'd1, 16'd2, 16'd3, 8'd8);
    f.id = 32'h0;
    f.chk = frame_sum(f);
    frames_q.push_back(f);
    f = cell_frame(8'hff, 4'd1, 4'd0, 16'd1, 16'd2, 16'd3, 8'd8);
    f.chk = f.chk ^ 8'h80;
    frames_q.push_back(f);
    f = cell_frame(8'h11, 4'd1, 4'd0, 16'd1, 16'd2, 16'd3, 8'd8);
    frames_q.push_back(f);
    frames_q.push_back(cell_frame(8'h00, 4'd1, 4'd0, 16'h0000, 16'hffff, 16'h1234, 8'd8));
    frames_q.push_back(cell_frame(8'hff, 4'd1, 4'd3, V_NONE, V_OPEN, 16'h8001, 8'd8));
    frames_q.push_back(cell_frame(8'h5a, 4'd1, 4'd15, 16'h0aaa, 16'h5555, 16'hfffc, 8'd8));
    frames_q.push_back(cell_frame(8'h00, 4'd1, 4'd14, V_OPEN, 16'h0101, V_NONE, 8'd8));
    frames_q.push_back(cell_frame(8'hff, 4'd2, 4'd0, 16'h4321, 16'h0042, 16'h7fff, 8'd8));
    frames_q.push_back(cell_frame(8'h5a, 4'd2, 4'd6, 16'h1111, 16'h2222, 16'h3333, 8'd5));
    frames_q.push_back(cell_frame(8'h00, 4'd3, 4'd0, 16'hffff, 16'hffff, 16'hffff, 8'd0));
    f = cell_frame(8'hff, 4'd15, 4'd15, 16'hffff, 16'hffff, 16'hffff, 8'd8);
    f.seq = 8'hff;
    f.chk = frame_sum(f);
    frames_q.push_back(f);
    f = cell_frame(8'h00, 4'd0, 4'd0, 16'h0000, 16'h0000, 16'h0000, 8'd8);
    f.seq = 8'h00;
    f.chk = frame_sum(f);
    frames_q.push_back(f);
    frames_q.push_back(cell_frame(8'h5a, 4'd4, 4'd9, 16'h0f0f, 16'hf0f0, 16'h00ff, 8'd7));
    drain();

    set_all(32'h0000_0000, 8'h00, 8'h00, 8'h00);
    queue_random(90);
    drain();

    calm = 1'b1;
    set_all($urandom, 8'($urandom), 8'($urandom), 8'($urandom));
    queue_random(90);
    drain();

    calm = 1'b0;
    set_all(32'h8000_0001, 8'hff, 8'hff, 8'h01);
    queue_random(90);
    drain();

    calm = 1'b1;
    set_all($urandom, 8'($urandom), 8'($urandom), 8'($urandom));
    queue_random(90);
    drain();

    if (errors == 0) begin
      $display("can_cell_reading_gatherer_unit_tb passed");
    end else begin
      $display("can_cell_reading_gatherer_unit_tb failed");
    end
    $finish;
  end

endmodule

### sim.f
design/ccrg_pkg.sv
design/ccrg_if.sv
design/ccrg_ctrl.sv
design/ccrg_dp.sv
design/can_cell_reading_gatherer_unit.sv
design/ccrg_checker.sv
tb/can_cell_reading_gatherer_unit_tb.sv
